>>> rtl/rtc_pkg.sv
`default_nettype none

package rtc_pkg;

	// Fixed field widths of the row and result words.
	localparam int FIELD_NODES = 16;
	localparam int ROW_W = 16;
	localparam int IDX_W = 4;
	localparam int NC_W = 5;

	// Default matrix depth handed to the top level.
	localparam int NODES_DEF = 16;

	// Configuration register map.
	localparam int ADDR_W = 1;
	localparam logic [ADDR_W-1:0] REG_NODE_COUNT = 1'b0;
	localparam logic [NC_W-1:0] NODE_COUNT_RESET = 5'd16;

	typedef enum logic [1:0] {
		ST_LOAD,
		ST_INIT,
		ST_CLOSE,
		ST_EMIT
	} rtc_state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;
		logic load_last;
		logic init;
		logic close;
		logic emit;
	} rtc_cmd_t;

	// Status from the datapath back to the controller.
	typedef struct packed {
		logic step_last;
	} rtc_sts_t;

endpackage

`default_nettype wire

>>> rtl/rtc_ctrl.sv
`default_nettype none

module rtc_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire logic              row_last,
	input  wire rtc_pkg::rtc_sts_t sts,
	output rtc_pkg::rtc_cmd_t      cmd,
	output logic                   busy
);

	rtc_pkg::rtc_state_t state_q, state_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rtc_pkg::ST_LOAD;
		end else begin
			state_q <= state_next;
		end
	end

	always_comb begin
		state_next = state_q;
		unique case (state_q)
			rtc_pkg::ST_LOAD: begin
				if (start && row_last) begin
					state_next = rtc_pkg::ST_INIT;
				end
			end
			rtc_pkg::ST_INIT: begin
				state_next = rtc_pkg::ST_CLOSE;
			end
			rtc_pkg::ST_CLOSE: begin
				if (sts.step_last) begin
					state_next = rtc_pkg::ST_EMIT;
				end
			end
			rtc_pkg::ST_EMIT: begin
				if (sts.step_last) begin
					state_next = rtc_pkg::ST_LOAD;
				end
			end
			default: begin
				state_next = rtc_pkg::ST_LOAD;
			end
		endcase
	end

	always_comb begin
		cmd = '0;
		busy = 1'b1;
		unique case (state_q)
			rtc_pkg::ST_LOAD: begin
				busy = 1'b0;
				cmd.load = start;
				cmd.load_last = start && row_last;
			end
			rtc_pkg::ST_INIT: begin
				cmd.init = 1'b1;
			end
			rtc_pkg::ST_CLOSE: begin
				cmd.close = 1'b1;
			end
			rtc_pkg::ST_EMIT: begin
				cmd.emit = 1'b1;
			end
			default: begin
				busy = 1'b1;
			end
		endcase
	end

endmodule

`default_nettype wire

>>> rtl/rtc_dpath.sv
`default_nettype none

module rtc_dpath #(
	parameter int NODES = rtc_pkg::NODES_DEF
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire rtc_pkg::rtc_cmd_t        cmd,
	input  wire logic [rtc_pkg::ROW_W-1:0] row_bits,
	input  wire logic [rtc_pkg::NC_W-1:0]  node_count,
	output rtc_pkg::rtc_sts_t             sts,
	output logic                          result_valid,
	output logic [rtc_pkg::IDX_W-1:0]      row_index,
	output logic [rtc_pkg::ROW_W-1:0]      reach_bits,
	output logic                          last_row
);

	// Rows beyond the field width can never take part in a closure.
	localparam int ROWS = (NODES < rtc_pkg::FIELD_NODES) ? NODES : rtc_pkg::FIELD_NODES;
	localparam int CW = $clog2(ROWS + 1);
	localparam int AW = $clog2(ROWS);

	logic [rtc_pkg::ROW_W-1:0] reach_q [ROWS];
	logic [CW-1:0]             cnt_q;
	logic [rtc_pkg::IDX_W-1:0] step_q;
	logic [rtc_pkg::NC_W-1:0]  n_q;
	logic [rtc_pkg::NC_W-1:0]  n_eff;
	logic [rtc_pkg::ROW_W-1:0] mask;
	logic [rtc_pkg::ROW_W-1:0] sel_row;
	logic [AW-1:0]             rd_idx;
	logic                      step_last;

	// Node count in use: zero counts as one, and it saturates at the depth.
	always_comb begin
		if (node_count == '0) begin
			n_eff = rtc_pkg::NC_W'(1);
		end else if (node_count > rtc_pkg::NC_W'(ROWS)) begin
			n_eff = rtc_pkg::NC_W'(ROWS);
		end else begin
			n_eff = node_count;
		end
	end

	assign mask = rtc_pkg::ROW_W'((17'd1 << n_q) - 17'd1);
	assign step_last = ({1'b0, step_q} == (n_q - rtc_pkg::NC_W'(1)));
	assign sts.step_last = step_last;

	// One shared read port: the pivot row while closing, the output row while emitting.
	assign rd_idx = step_q[AW-1:0];
	assign sel_row = reach_q[rd_idx];

	always_ff @(posedge clk) begin
		for (int i = 0; i < ROWS; i++) begin
			if (cmd.load && (cnt_q == CW'(i))) begin
				reach_q[i] <= row_bits;
			end else if (cmd.init) begin
				reach_q[i] <= (((CW'(i) < cnt_q) ? reach_q[i] : '0) & mask)
					| (rtc_pkg::ROW_W'(1) << i);
			end else if (cmd.close && reach_q[i][step_q]) begin
				reach_q[i] <= reach_q[i] | sel_row;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			step_q <= '0;
			n_q <= rtc_pkg::NODE_COUNT_RESET;
			result_valid <= 1'b0;
		end else begin
			if (cmd.load && (cnt_q != CW'(ROWS))) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (cmd.init) begin
				cnt_q <= '0;
			end
			if (cmd.load_last) begin
				n_q <= n_eff;
			end
			if (cmd.init || ((cmd.close || cmd.emit) && step_last)) begin
				step_q <= '0;
			end else if (cmd.close || cmd.emit) begin
				step_q <= step_q + rtc_pkg::IDX_W'(1);
			end
			result_valid <= cmd.emit;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			row_index <= step_q;
			reach_bits <= sel_row & mask;
			last_row <= step_last;
		end
	end

	a_self_reach: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> reach_bits[row_index])
		else $error("closure row does not reach its own node");

	a_index_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> ({1'b0, row_index} < n_q))
		else $error("result row index beyond node count");

	a_rows_in_order: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && !last_row) |=>
			(result_valid && (row_index == $past(row_index) + rtc_pkg::IDX_W'(1))))
		else $error("closure rows not emitted back to back in order");

endmodule

`default_nettype wire

>>> rtl/reflexive_transitive_closure.sv
`default_nettype none

// Reflexive transitive closure of a directed graph of up to 16 nodes (Warshall).
// Adjacency rows are written one word per cycle with start while busy is low; row_last
// marks the final row. Rows not sent before row_last read as zero, rows past the node
// count are ignored, and bits at or above node_count are masked. After the last row the
// block stays busy, n being the node count in use: a first pass sets the diagonal and
// masks the rows, a pivot pass applies one pivot per node (the pivot row is read from the
// single shared row read port and ORed into every row holding the pivot bit), and an
// output pass streams out the result. The n result words appear on consecutive cycles,
// each for exactly one cycle with result_valid high, row 0 first, last_row on the final one.
// The receiver cannot stall the result stream and must take every word as it comes.
// node_count is a register at byte address 0 of the APB port and should be written only
// while busy is low and no results are pending.
module reflexive_transitive_closure #(
	parameter int NODES = rtc_pkg::NODES_DEF
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,

	input  wire logic                        psel,
	input  wire logic                        penable,
	input  wire logic                        pwrite,
	input  wire logic [rtc_pkg::ADDR_W-1:0]  paddr,
	input  wire logic [31:0]                 pwdata,
	output logic      [31:0]                 prdata,
	output logic                             pready,

	input  wire logic                        start,
	output logic                             busy,
	input  wire logic [rtc_pkg::ROW_W-1:0]   row_bits,
	input  wire logic                        row_last,

	output logic                             result_valid,
	output logic [rtc_pkg::IDX_W-1:0]        row_index,
	output logic [rtc_pkg::ROW_W-1:0]        reach_bits,
	output logic                             last_row
);

	logic [rtc_pkg::NC_W-1:0] node_count_q;
	rtc_pkg::rtc_cmd_t        cmd;
	rtc_pkg::rtc_sts_t        sts;

	// The APB port never inserts wait states.
	assign pready = 1'b1;

	// The node count register takes the low five bits of the written word.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_count_q <= rtc_pkg::NODE_COUNT_RESET;
		end else if (psel && penable && pwrite && (paddr == rtc_pkg::REG_NODE_COUNT)) begin
			node_count_q <= pwdata[rtc_pkg::NC_W-1:0];
		end
	end

	// Reads of unmapped addresses return zero.
	always_comb begin
		prdata = '0;
		if (paddr == rtc_pkg::REG_NODE_COUNT) begin
			prdata = {{(32 - rtc_pkg::NC_W){1'b0}}, node_count_q};
		end
	end

	// The controller sequences loading, the diagonal pass, the pivots and the output.
	rtc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.row_last (row_last),
		.sts      (sts),
		.cmd      (cmd),
		.busy     (busy)
	);

	// The datapath holds the matrix, the row and pivot counters and the result register.
	rtc_dpath #(
		.NODES (NODES)
	) u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.row_bits     (row_bits),
		.node_count   (node_count_q),
		.sts          (sts),
		.result_valid (result_valid),
		.row_index    (row_index),
		.reach_bits   (reach_bits),
		.last_row     (last_row)
	);

endmodule

`default_nettype wire

>>> tb/testbench.sv
`default_nettype none

// Testbench for the reflexive transitive closure block.
//
// Adjacency rows go in as words on the start/busy command port, one row per word, and the
// node count is set through the APB port while the block is idle. A scoreboard object keeps
// its own copy of the adjacency matrix and of the node count. When the word marked row_last
// is accepted, it runs Warshall's closure on that copy and queues the closure rows that the
// block must emit. The monitor compares every result word, field by field, with the oldest
// queued row.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	// Long enough for the block to finish a full 16 node closure after the last expected
	// word has already been seen.
	localparam int SETTLE_CYCLES = 40;
	localparam int CYCLE_LIMIT = 300000;
	localparam int RANDOM_ITEMS = 220;
	localparam int IDLE_PERCENT = 17;

	// Closure rows expected from the block, oldest first, and a private copy of the matrix.
	class closure_scoreboard;
		typedef struct packed {
			logic [rtc_pkg::IDX_W-1:0] idx;
			logic [rtc_pkg::ROW_W-1:0] bits;
			logic                      lst;
		} closure_row_t;

		logic [rtc_pkg::ROW_W-1:0] adj_rows [rtc_pkg::FIELD_NODES];
		int unsigned               rows_loaded;
		logic [rtc_pkg::NC_W-1:0]  node_cfg;
		closure_row_t              closure_rows [$];
		int                        errors;

		function new();
			foreach (adj_rows[i])
				adj_rows[i] = '0;
			rows_loaded = 0;
			node_cfg = rtc_pkg::NODE_COUNT_RESET;
			errors = 0;
		endfunction

		function void set_node_count(logic [rtc_pkg::NC_W-1:0] value);
			node_cfg = value;
		endfunction

		// A node count of zero acts as one; anything above the matrix size saturates.
		function int nodes_in_use();
			int n;
			n = node_cfg;
			if (n == 0)
				n = 1;
			if (n > rtc_pkg::FIELD_NODES)
				n = rtc_pkg::FIELD_NODES;
			return n;
		endfunction

		function int pending();
			return closure_rows.size();
		endfunction

		// Called for every accepted row word. The row_last word triggers the closure.
		function void note_row(logic [rtc_pkg::ROW_W-1:0] bits, logic lst);
			int n;
			int i;
			int k;
			logic [rtc_pkg::ROW_W-1:0] mask;
			logic [rtc_pkg::ROW_W-1:0] pivot_row;
			closure_row_t entry;
			if (rows_loaded < rtc_pkg::FIELD_NODES) begin
				adj_rows[rows_loaded] = bits;
				rows_loaded++;
			end
			if (!lst)
				return;
			n = nodes_in_use();
			mask = rtc_pkg::ROW_W'((17'd1 << n) - 17'd1);
			// Rows that never arrived count as empty.
			for (i = rows_loaded; i < n; i++)
				adj_rows[i] = '0;
			for (i = 0; i < n; i++)
				adj_rows[i] = (adj_rows[i] & mask) | (rtc_pkg::ROW_W'(1) << i);
			for (k = 0; k < n; k++) begin
				pivot_row = adj_rows[k];
				for (i = 0; i < n; i++)
					if (adj_rows[i][k])
						adj_rows[i] = adj_rows[i] | pivot_row;
			end
			for (i = 0; i < n; i++) begin
				entry.idx = rtc_pkg::IDX_W'(i);
				entry.bits = adj_rows[i] & mask;
				entry.lst = (i == n - 1);
				closure_rows.push_back(entry);
			end
			rows_loaded = 0;
		endfunction

		task report_mismatch(input string msg);
			$display("MISMATCH at %0t: %s", $realtime, msg);
			errors++;
		endtask

		task check_result(input logic [rtc_pkg::IDX_W-1:0] idx,
				input logic [rtc_pkg::ROW_W-1:0] bits, input logic lst);
			closure_row_t want;
			if (closure_rows.size() == 0) begin
				report_mismatch($sformatf("unexpected word row_index=%0d reach_bits=%h",
					idx, bits));
				return;
			end
			want = closure_rows.pop_front();
			if (idx !== want.idx)
				report_mismatch($sformatf("row_index %0d, want %0d", idx, want.idx));
			if (bits !== want.bits)
				report_mismatch($sformatf("row %0d reach_bits %h, want %h",
					want.idx, bits, want.bits));
			if (lst !== want.lst)
				report_mismatch($sformatf("row %0d last_row %b, want %b",
					want.idx, lst, want.lst));
		endtask
	endclass

	logic clk = 1'b0;
	logic arst_n;
	logic psel;
	logic penable;
	logic pwrite;
	logic [rtc_pkg::ADDR_W-1:0] paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic pready;
	logic start;
	logic busy;
	logic [rtc_pkg::ROW_W-1:0] row_bits;
	logic row_last;
	logic result_valid;
	logic [rtc_pkg::IDX_W-1:0] row_index;
	logic [rtc_pkg::ROW_W-1:0] reach_bits;
	logic last_row;

	closure_scoreboard sb = new();
	int unsigned cycle_count = 0;
	int items_sent = 0;
	bit idle_on = 1'b1;

	reflexive_transitive_closure uut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.start(start),
		.busy(busy),
		.row_bits(row_bits),
		.row_last(row_last),
		.result_valid(result_valid),
		.row_index(row_index),
		.reach_bits(reach_bits),
		.last_row(last_row)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Watchdog. A hung block or a lost word ends the run here.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d words still due", cycle_count,
				sb.pending());
			$display("testbench failed");
			$finish;
		end
	end

	// Result words cannot be held off, so every cycle with result_valid high is one word.
	// Sampling on the falling edge keeps the check clear of the rising edge updates.
	always @(negedge clk) begin
		if (arst_n && result_valid)
			sb.check_result(row_index, reach_bits, last_row);
	end

	// Drives one row word and returns at the rising edge that accepts it. Every task here is
	// entered at a rising edge, and start stays high when rows follow back to back, so it is
	// never lowered and raised in the same step.
	task automatic send_row(input logic [rtc_pkg::ROW_W-1:0] bits, input logic lst);
		logic taken;
		start <= 1'b1;
		row_bits <= bits;
		row_last <= lst;
		do begin
			@(negedge clk);
			taken = !busy;
			@(posedge clk);
		end while (!taken);
		sb.note_row(bits, lst);
		items_sent++;
	endtask

	// Random gaps between words when enabled; each further idle cycle is added with odds of IDLE_PERCENT in a hundred.
	task automatic sender_gap();
		if (idle_on) begin
			while ($urandom_range(0, 99) < IDLE_PERCENT) begin
				start <= 1'b0;
				@(posedge clk);
			end
		end
	endtask

	// Holds off the sender until every queued closure row has come out, then lets the
	// block settle in case it is still working on rows that produce no output.
	task automatic wait_quiet();
		start <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES)
			@(posedge clk);
	endtask

	// APB write of the node count. Upper data bits are random; only the low five matter.
	task automatic write_node_count(input logic [rtc_pkg::NC_W-1:0] value);
		logic rdy;
		wait_quiet();
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= rtc_pkg::REG_NODE_COUNT;
		pwdata <= ($urandom() & ~32'h1F) | 32'(value);
		@(posedge clk);
		penable <= 1'b1;
		do begin
			@(negedge clk);
			rdy = pready;
			@(posedge clk);
		end while (!rdy);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		sb.set_node_count(value);
	endtask

	// Random adjacency row. Sparse rows leave the closure something to do; dense rows and
	// single edges fill in the rest.
	function automatic logic [rtc_pkg::ROW_W-1:0] random_row();
		case ($urandom_range(0, 3))
			0: return rtc_pkg::ROW_W'($urandom());
			1: return rtc_pkg::ROW_W'($urandom() & $urandom());
			2: return rtc_pkg::ROW_W'($urandom() & $urandom() & $urandom());
			default: return rtc_pkg::ROW_W'(1) << $urandom_range(0, rtc_pkg::ROW_W - 1);
		endcase
	endfunction

	// One graph: mostly exactly one row per node, sometimes rows missing or rows extra,
	// with the extra case now and then running past the sixteen row store.
	task automatic send_random_graph();
		int n;
		int rows;
		int i;
		n = sb.nodes_in_use();
		case ($urandom_range(0, 19))
			0, 1, 2: rows = (n > 1) ? $urandom_range(1, n - 1) : 1;
			3, 4, 5: rows = n + $urandom_range(1, 5);
			default: rows = n;
		endcase
		for (i = 0; i < rows; i++) begin
			sender_gap();
			send_row(random_row(), i == rows - 1);
		end
	endtask

	initial begin
		int nc_plan [10];
		int phase;
		int graphs;
		int g;
		int random_start;

		arst_n <= 1'b0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		start <= 1'b0;
		row_bits <= '0;
		row_last <= 1'b0;
		repeat (8)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part, starting from the reset node count of sixteen.
		// A lone full row: row 0 reaches everything, every other row is missing.
		send_row(16'hFFFF, 1'b1);
		sender_gap();
		// Empty graph: only the diagonal survives.
		send_row(16'h0000, 1'b1);
		// A four node cycle, so each of the first four nodes reaches all four.
		send_row(16'h0002, 1'b0);
		send_row(16'h0004, 1'b0);
		send_row(16'h0008, 1'b0);
		send_row(16'h0001, 1'b1);

		// Node count changed in the middle of a load: the count at the last row governs,
		// and bits at or above it are masked.
		send_row(16'h8004, 1'b0);
		send_row(16'h0001, 1'b0);
		write_node_count(5'd3);
		send_row(16'hFFFF, 1'b1);

		// Smallest graph, and zero acting as one node.
		write_node_count(5'd1);
		send_row(16'hFFFE, 1'b1);
		write_node_count(5'd0);
		send_row(16'h0000, 1'b1);

		// Rows past the node count are ignored.
		write_node_count(5'd2);
		send_row(16'h0002, 1'b0);
		send_row(16'h0000, 1'b0);
		send_row(16'hFFFF, 1'b0);
		send_row(16'hFFFF, 1'b0);
		send_row(16'h0003, 1'b1);

		// Counts above sixteen saturate.
		write_node_count(5'd31);
		send_row(16'h8000, 1'b1);
		write_node_count(5'd17);
		send_row(16'h0000, 1'b0);
		send_row(16'h4001, 1'b1);

		// Random part: one node count per phase, a few graphs each. The fourth to sixth
		// phases run with the sender never idle.
		nc_plan = '{16, 5, 1, 31, 3, 8, 0, 17, 12, 2};
		random_start = items_sent;
		phase = 0;
		while (items_sent - random_start < RANDOM_ITEMS) begin
			if (phase < 10)
				write_node_count(rtc_pkg::NC_W'(nc_plan[phase]));
			else
				write_node_count(rtc_pkg::NC_W'($urandom_range(0, 31)));
			idle_on = !(phase >= 3 && phase <= 5);
			graphs = $urandom_range(2, 5);
			for (g = 0; g < graphs; g++) begin
				send_random_graph();
				// Now and then the sender waits until the whole closure has come out.
				if ($urandom_range(0, 9) == 0)
					wait_quiet();
			end
			phase++;
		end

		wait_quiet();
		if (sb.pending() != 0)
			sb.report_mismatch($sformatf("%0d words never arrived", sb.pending()));
		if (sb.errors == 0) begin
			$display("testbench passed");
		end else begin
			$display("testbench failed");
		end
		$finish;
	end

endmodule

`default_nettype wire

>>> reflexive_transitive_closure.f
rtl/rtc_pkg.sv
rtl/rtc_ctrl.sv
rtl/rtc_dpath.sv
rtl/reflexive_transitive_closure.sv
tb/testbench.sv
